// ===== rtl/core/mbat_pkg.sv =====
package mbat_pkg;

  localparam int unsigned NumElements  = 64;
  localparam int unsigned TableEntries = 32;
  localparam int unsigned IdxW  = $clog2(TableEntries);
  localparam int unsigned CntW  = $clog2(TableEntries + 1);
  localparam int unsigned PopW  = 7;

  localparam logic [63:0] ElemMask = (NumElements >= 64) ? {64{1'b1}} :
      ((64'd1 << NumElements) - 64'd1);

  typedef enum logic [1:0] {
    FuncInsert  = 2'd0,
    FuncQuery   = 2'd1,
    FuncMarker  = 2'd2,
    FuncOverlap = 2'd3
  } func_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;       // capture the input word, clear per-word flags
    logic [IdxW-1:0] rd_idx;     // entry read this cycle
    logic [IdxW-1:0] chk_idx;    // entry whose read data is present
    logic [IdxW-1:0] row_idx;    // row under test in the marker pass
    logic            scan_chk;   // containment and overlap check
    logic            evict_chk;  // drop proper subsets, find a free slot
    logic            store;      // store the new set or flag overflow
    logic            mark_set;   // add the marker to the kept mask
    logic            mark_wr;    // write back entry chk_idx with the marker
    logic            row_load;   // capture the row under test
    logic            kill_chk;   // compare the row under test with chk_idx
    logic            kill_end;   // drop the row under test or note its size
    logic            emit;       // copy the result into the output register
  } mbat_cmd_t;

  typedef struct packed {
    logic contained;
    logic mark_ok;
    logic out_free;
  } mbat_sts_t;

  function automatic logic [PopW-1:0] pop64(input logic [63:0] v);
    logic [PopW-1:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) n = n + PopW'(v[i]);
    return n;
  endfunction

endpackage

// ===== rtl/core/mbat_ram.sv =====
module mbat_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/core/mbat_ctrl.sv =====
module mbat_ctrl import mbat_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] func_i,
  input  mbat_sts_t  sts_i,
  output mbat_cmd_t  cmd_o,
  output logic       idle_o
);
  typedef enum logic [3:0] {
    StIdle, StScan, StEvict, StStore, StMark, StKillRow, StKillCmp, StKillEnd, StDone
  } state_e;

  state_e          state_q;
  logic [IdxW:0]   i_q;    // sweep counter, one extra count for the registered read
  logic [IdxW-1:0] row_q;  // row under test in the marker pass
  func_e           func_q;

  localparam logic [IdxW:0] Last = (IdxW+1)'(TableEntries);

  always_comb begin
    cmd_o = '0;
    cmd_o.load    = start_i;
    cmd_o.rd_idx  = i_q[IdxW-1:0];
    cmd_o.chk_idx = IdxW'(i_q - 1'b1);
    cmd_o.row_idx = row_q;
    unique case (state_q)
      StScan:  cmd_o.scan_chk  = (i_q != '0);
      StEvict: cmd_o.evict_chk = (i_q != '0);
      StStore: cmd_o.store = 1'b1;
      StMark: begin
        cmd_o.mark_set = (i_q == '0) && sts_i.mark_ok;
        cmd_o.mark_wr  = (i_q != '0);
      end
      StKillRow: cmd_o.rd_idx = row_q;
      StKillCmp: begin
        cmd_o.row_load = (i_q == '0);
        cmd_o.kill_chk = (i_q != '0);
      end
      StKillEnd: cmd_o.kill_end = 1'b1;
      StDone:    cmd_o.emit = sts_i.out_free;
      default: ;
    endcase
  end

  assign idle_o = state_q == StIdle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      i_q <= '0;
      row_q <= '0;
      func_q <= FuncInsert;
    end else begin
      unique case (state_q)
        StIdle: if (start_i) begin
          func_q <= func_e'(func_i);
          i_q <= '0;
          if (func_i == FuncMarker) state_q <= StMark;
          else state_q <= StScan;
        end
        StScan: if (i_q == Last) begin
          i_q <= '0;
          if (func_q == FuncInsert && !sts_i.contained) state_q <= StEvict;
          else state_q <= StDone;
        end else i_q <= i_q + 1'b1;
        StEvict: if (i_q == Last) begin
          i_q <= '0;
          state_q <= StStore;
        end else i_q <= i_q + 1'b1;
        StStore: state_q <= StDone;
        StMark: begin
          if (i_q == '0 && !sts_i.mark_ok) state_q <= StDone;
          else if (i_q == Last) begin
            i_q <= '0;
            row_q <= '0;
            state_q <= StKillRow;
          end else i_q <= i_q + 1'b1;
        end
        StKillRow: state_q <= StKillCmp;
        StKillCmp: if (i_q == Last) begin
          i_q <= '0;
          state_q <= StKillEnd;
        end else i_q <= i_q + 1'b1;
        StKillEnd: begin
          if (row_q == IdxW'(TableEntries - 1)) state_q <= StDone;
          else begin
            row_q <= row_q + 1'b1;
            state_q <= StKillRow;
          end
        end
        StDone: if (sts_i.out_free) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ===== rtl/core/mbat_dp.sv =====
module mbat_dp import mbat_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mbat_cmd_t   cmd_i,
  input  logic        ready_i,
  input  logic [1:0]  func_i,
  input  logic [63:0] set_bits_i,
  input  logic [5:0]  marker_index_i,
  output mbat_sts_t   sts_o,
  output logic        valid_o,
  output logic        accepted_o,
  output logic        found_o,
  output logic [6:0]  best_overlap_o,
  output logic [5:0]  entry_count_o,
  output logic [6:0]  largest_size_o,
  output logic        overflow_o
);
  logic [TableEntries-1:0] valid_q;
  logic [63:0]     kmask_q, bits_q, newset_q, row_i_q;
  func_e           func_q;
  logic [5:0]      mark_q;
  logic            contained_q, free_q, kill_q, accepted_q, ovf_q;
  logic [IdxW-1:0] free_idx_q;
  logic [PopW-1:0] best_q, largest_q;
  logic [CntW-1:0] count_q;
  logic            out_v_q, out_acc_q, out_found_q, out_ovf_q;
  logic [6:0]      out_best_q, out_large_q;
  logic [5:0]      out_cnt_q;

  logic [63:0]     rdata, wdata, mark_bit;
  logic            we;
  logic [IdxW-1:0] waddr;
  logic            v_chk, v_row, hit_now, evict_now, kill_now, out_free;
  logic [PopW-1:0] ov_now, new_pop, row_pop;

  assign mark_bit = (64'd1 << mark_q) & ElemMask;
  assign v_chk    = valid_q[cmd_i.chk_idx];
  assign v_row    = valid_q[cmd_i.row_idx];
  assign hit_now  = v_chk && ((bits_q & ~rdata) == '0);
  assign ov_now   = pop64(bits_q & rdata);
  assign new_pop  = pop64(newset_q);
  assign row_pop  = pop64(row_i_q);
  assign out_free = !out_v_q || ready_i;

  // A stored set is evicted when it is a proper subset of the new set.
  assign evict_now = cmd_i.evict_chk && v_chk &&
      ((rdata & ~newset_q) == '0) && (rdata != newset_q);

  // Rows killed earlier in the marker pass are always covered by a live
  // row too, so checking against the live valid bits is enough.
  assign kill_now = cmd_i.kill_chk && v_row && v_chk && (cmd_i.chk_idx != cmd_i.row_idx) &&
      ((row_i_q & ~rdata) == '0) &&
      ((row_i_q != rdata) || (cmd_i.chk_idx < cmd_i.row_idx));

  always_comb begin
    we = 1'b0;
    waddr = cmd_i.chk_idx;
    wdata = rdata | mark_bit;
    if (cmd_i.store) begin
      we = free_q;
      waddr = free_idx_q;
      wdata = newset_q;
    end else if (cmd_i.mark_wr) begin
      we = v_chk;
    end
  end

  mbat_ram #(.Width(64), .Depth(TableEntries)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(cmd_i.rd_idx), .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      kmask_q <= '0;
      largest_q <= '0;
      count_q <= '0;
      contained_q <= 1'b0;
      free_q <= 1'b0;
      free_idx_q <= '0;
      kill_q <= 1'b0;
      accepted_q <= 1'b0;
      ovf_q <= 1'b0;
      best_q <= '0;
      out_v_q <= 1'b0;
      out_acc_q <= 1'b0;
      out_found_q <= 1'b0;
      out_best_q <= '0;
      out_cnt_q <= '0;
      out_large_q <= '0;
      out_ovf_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        contained_q <= 1'b0;
        free_q <= 1'b0;
        kill_q <= 1'b0;
        accepted_q <= 1'b0;
        ovf_q <= 1'b0;
        best_q <= '0;
      end
      if (cmd_i.scan_chk) begin
        if (hit_now) contained_q <= 1'b1;
        if (v_chk && ov_now > best_q) best_q <= ov_now;
      end
      if (evict_now) valid_q[cmd_i.chk_idx] <= 1'b0;
      if (cmd_i.evict_chk && !free_q && (!v_chk || evict_now)) begin
        free_q <= 1'b1;
        free_idx_q <= cmd_i.chk_idx;
      end
      if (cmd_i.store) begin
        if (free_q) begin
          valid_q[free_idx_q] <= 1'b1;
          accepted_q <= 1'b1;
          if (new_pop > largest_q) largest_q <= new_pop;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.mark_set) begin
        kmask_q <= kmask_q | mark_bit;
        accepted_q <= 1'b1;
      end
      if (kill_now) kill_q <= 1'b1;
      if (cmd_i.kill_end) begin
        kill_q <= 1'b0;
        if (kill_q) valid_q[cmd_i.row_idx] <= 1'b0;
        else if (v_row && row_pop > largest_q) largest_q <= row_pop;
      end
      if (cmd_i.store && free_q) count_q <= count_q + 1'b1;
      else if (evict_now || (cmd_i.kill_end && kill_q)) count_q <= count_q - 1'b1;
      if (cmd_i.emit) begin
        out_v_q <= 1'b1;
        out_acc_q <= accepted_q;
        out_found_q <= (func_q == FuncQuery) && contained_q;
        out_best_q <= (func_q == FuncOverlap) ? best_q : '0;
        out_cnt_q <= 6'(count_q);
        out_large_q <= largest_q;
        out_ovf_q <= ovf_q;
      end else if (ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_e'(func_i);
      bits_q <= set_bits_i & ElemMask;
      mark_q <= marker_index_i;
      newset_q <= (set_bits_i | kmask_q) & ElemMask;
    end
    if (cmd_i.row_load) row_i_q <= rdata;
  end

  // The last entry of the scan is still being checked when the controller
  // decides on the evict pass, so its hit is folded in directly.
  assign sts_o.contained = contained_q || (cmd_i.scan_chk && hit_now);
  assign sts_o.mark_ok   = (32'(mark_q) < NumElements) && !kmask_q[mark_q];
  assign sts_o.out_free  = out_free;

  assign valid_o        = out_v_q;
  assign accepted_o     = out_acc_q;
  assign found_o        = out_found_q;
  assign best_overlap_o = out_best_q;
  assign entry_count_o  = out_cnt_q;
  assign largest_size_o = out_large_q;
  assign overflow_o     = out_ovf_q;
endmodule

// ===== rtl/core/maximal_bitset_antichain_table.sv =====
// Channel | Direction | Fields
// in      | input     | func_i, set_bits_i, marker_index_i (valid_i / ready_o)
// out     | output    | accepted_o .. overflow_o           (valid_o / ready_i)
//
// Each word sweeps the 32-entry table through a RAM with registered read, one
// entry per cycle. A query or overlap word takes one scan; an insert scans and,
// unless the set is already covered, then evicts and stores; a keep-marker word
// with a kept or out-of-range marker goes straight to its result; and a keep-marker
// word that applies writes the marker back, then checks the rows pairwise. Reset
// clears valid bits, the marker mask and the size record; entry data is undefined
// until written. Results wait in an output register; a word finishing while
// the previous result is still untaken stalls there, and no new word is
// accepted until it has moved out.
module maximal_bitset_antichain_table import mbat_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [1:0]  func_i,
  input  logic [63:0] set_bits_i,
  input  logic [5:0]  marker_index_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        accepted_o,
  output logic        found_o,
  output logic [6:0]  best_overlap_o,
  output logic [5:0]  entry_count_o,
  output logic [6:0]  largest_size_o,
  output logic        overflow_o
);
  mbat_cmd_t cmd;
  mbat_sts_t sts;
  logic idle, start;

  // A new word is taken only while the controller is idle.
  assign ready_o = idle;
  assign start   = valid_i && idle;

  mbat_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .func_i,
    .sts_i(sts), .cmd_o(cmd), .idle_o(idle)
  );

  mbat_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .ready_i, .func_i, .set_bits_i, .marker_index_i,
    .sts_o(sts), .valid_o, .accepted_o, .found_o, .best_overlap_o, .entry_count_o,
    .largest_size_o, .overflow_o
  );

  // A pending result stays offered, unchanged, until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(entry_count_o) &&
    $stable(largest_size_o) && $stable(accepted_o)) else $error("result dropped");
  // The stored count never exceeds the table depth.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, entry_count_o} <= 7'(TableEntries)) else $error("count overflow");
  // Largest size never decreases.
  a_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    largest_size_o >= $past(largest_size_o)) else $error("size shrank");
endmodule

// ===== tb/maximal_bitset_antichain_table_test.sv =====
module maximal_bitset_antichain_table_test import mbat_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted result word.
  typedef struct packed {
    logic       accepted;
    logic       found;
    logic [6:0] best_overlap;
    logic [5:0] entry_count;
    logic [6:0] largest_size;
    logic       overflow;
  } table_answer_t;

  // The scoreboard keeps its own copy of the set table and a queue of
  // answers that the block still owes.
  class antichain_scoreboard;
    logic [63:0]   sets_q[TableEntries];
    logic          live_q[TableEntries];
    logic [63:0]   marker_mask;
    logic [6:0]    largest_seen;
    table_answer_t owed_q[$];
    int            errors;
    int            checked;

    function new();
      for (int i = 0; i < TableEntries; i++) begin
        sets_q[i] = '0;
        live_q[i] = 1'b0;
      end
      marker_mask = '0;
      largest_seen = '0;
      errors = 0;
      checked = 0;
    endfunction

    function automatic logic [6:0] ones(logic [63:0] v);
      logic [6:0] n;
      n = '0;
      for (int i = 0; i < 64; i++) n += 7'(v[i]);
      return n;
    endfunction

    function automatic logic covered(logic [63:0] m);
      for (int i = 0; i < TableEntries; i++)
        if (live_q[i] && (m & ~sets_q[i]) == '0) return 1'b1;
      return 1'b0;
    endfunction

    function automatic void grow_largest(logic [63:0] s);
      if (ones(s) > largest_seen) largest_seen = ones(s);
    endfunction

    // Note an accepted input word and predict its answer.
    function automatic void note_word(func_e fn, logic [63:0] bits_in, logic [5:0] mark);
      table_answer_t a;
      logic [63:0] bits, s, b;
      int free_slot, cnt;
      logic drop[TableEntries];
      logic [6:0] best;
      a = '0;
      bits = bits_in & ElemMask;
      case (fn)
        FuncInsert: begin
          if (!covered(bits)) begin
            s = (bits | marker_mask) & ElemMask;
            free_slot = -1;
            for (int i = 0; i < TableEntries; i++) begin
              if (live_q[i] && (sets_q[i] & ~s) == '0 && sets_q[i] != s) live_q[i] = 1'b0;
              if (!live_q[i] && free_slot < 0) free_slot = i;
            end
            if (free_slot >= 0) begin
              sets_q[free_slot] = s;
              live_q[free_slot] = 1'b1;
              grow_largest(s);
              a.accepted = 1'b1;
            end else begin
              a.overflow = 1'b1;
            end
          end
        end
        FuncQuery: a.found = covered(bits);
        FuncMarker: begin
          b = 64'd1 << mark;
          if (mark < NumElements && (marker_mask & b) == '0) begin
            marker_mask |= b;
            for (int i = 0; i < TableEntries; i++) if (live_q[i]) sets_q[i] |= b;
            for (int i = 0; i < TableEntries; i++) begin
              drop[i] = 1'b0;
              if (live_q[i])
                for (int j = 0; j < TableEntries; j++)
                  if (j != i && live_q[j] && (sets_q[i] & ~sets_q[j]) == '0 &&
                      (sets_q[i] != sets_q[j] || j < i)) drop[i] = 1'b1;
            end
            for (int i = 0; i < TableEntries; i++) begin
              if (drop[i]) live_q[i] = 1'b0;
              else if (live_q[i]) grow_largest(sets_q[i]);
            end
            a.accepted = 1'b1;
          end
        end
        default: begin
          best = '0;
          for (int i = 0; i < TableEntries; i++)
            if (live_q[i] && ones(bits & sets_q[i]) > best) best = ones(bits & sets_q[i]);
          a.best_overlap = best;
        end
      endcase
      cnt = 0;
      for (int i = 0; i < TableEntries; i++) if (live_q[i]) cnt++;
      a.entry_count = 6'(cnt);
      a.largest_size = largest_seen;
      owed_q = {owed_q, a};
    endfunction

    // Compare one result word against the oldest owed answer.
    function automatic void check_word(table_answer_t got);
      table_answer_t exp;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $realtime, got);
        errors++;
        return;
      end
      exp = owed_q.pop_front();
      checked++;
      if (got.accepted !== exp.accepted) begin
        $display("%0t: accepted expected %b actual %b", $realtime, exp.accepted, got.accepted);
        errors++;
      end
      if (got.found !== exp.found) begin
        $display("%0t: found expected %b actual %b", $realtime, exp.found, got.found);
        errors++;
      end
      if (got.best_overlap !== exp.best_overlap) begin
        $display("%0t: best_overlap expected %0d actual %0d", $realtime,
                 exp.best_overlap, got.best_overlap);
        errors++;
      end
      if (got.entry_count !== exp.entry_count) begin
        $display("%0t: entry_count expected %0d actual %0d", $realtime,
                 exp.entry_count, got.entry_count);
        errors++;
      end
      if (got.largest_size !== exp.largest_size) begin
        $display("%0t: largest_size expected %0d actual %0d", $realtime,
                 exp.largest_size, got.largest_size);
        errors++;
      end
      if (got.overflow !== exp.overflow) begin
        $display("%0t: overflow expected %b actual %b", $realtime, exp.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        ready_o;
  logic [1:0]  func_i = '0;
  logic [63:0] set_bits_i = '0;
  logic [5:0]  marker_index_i = '0;
  logic        valid_o;
  logic        ready_i = 1'b0;
  logic        accepted_o, found_o, overflow_o;
  logic [6:0]  best_overlap_o, largest_size_o;
  logic [5:0]  entry_count_o;

  // Idle rates in percent for the sender and the receiver.
  int send_idle = 37;
  int recv_idle = 77;
  int words_sent = 0;
  int marker_words = 0;

  antichain_scoreboard board = new();

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  maximal_bitset_antichain_table dut (
    .clk_i, .rst_ni, .valid_i, .ready_o, .func_i, .set_bits_i, .marker_index_i,
    .valid_o, .ready_i, .accepted_o, .found_o, .best_overlap_o, .entry_count_o,
    .largest_size_o, .overflow_o
  );

  // Both handshakes are sampled at the rising edge, before the driving
  // nonblocking assignments of that edge take effect.
  always @(posedge clk_i) begin
    if (rst_ni && valid_i && ready_o)
      board.note_word(func_e'(func_i), set_bits_i, marker_index_i);
    if (rst_ni && valid_o && ready_i)
      board.check_word({accepted_o, found_o, best_overlap_o, entry_count_o,
                        largest_size_o, overflow_o});
  end

  // The receiver stalls at random at the current rate.
  always @(posedge clk_i) begin
    ready_i <= ($urandom_range(99) >= recv_idle);
  end

  // Offer one word, idling first at random, and hold it until accepted.
  // Valid is left high after acceptance so that the next word can follow
  // without a second assignment in the same time step.
  task automatic send_word(func_e fn, logic [63:0] bits, logic [5:0] mark);
    while ($urandom_range(99) < send_idle) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    func_i <= fn;
    set_bits_i <= bits;
    marker_index_i <= mark;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    words_sent++;
    if (fn == FuncMarker) marker_words++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Sparse sets keep the antichain interesting; dense and near-full ones stress
  // containment and eviction.
  function automatic logic [63:0] pick_set();
    logic [63:0] v;
    case ($urandom_range(9))
      0: v = rand64();
      1: v = ~(64'd1 << $urandom_range(63));
      2: v = 64'd1 << $urandom_range(63);
      default: v = rand64() & rand64() & rand64() & rand64();
    endcase
    return v;
  endfunction

  task automatic random_phase(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 45) send_word(FuncInsert, pick_set(), 6'($urandom()));
      else if (r < 65) send_word(FuncQuery, pick_set(), 6'($urandom()));
      else if (r < 85) send_word(FuncOverlap, pick_set(), 6'($urandom()));
      else send_word(FuncMarker, pick_set(), 6'($urandom()));
    end
  endtask

  initial begin
    int guard;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty table, extremes, duplicates, kept markers and a full table.
    send_word(FuncQuery, 64'd0, 6'd0);
    send_word(FuncOverlap, '1, 6'd0);
    send_word(FuncInsert, 64'd0, 6'd0);
    send_word(FuncQuery, 64'd0, 6'd0);
    send_word(FuncInsert, 64'h1, 6'd0);
    send_word(FuncInsert, 64'h1, 6'd0);
    send_word(FuncInsert, 64'h2, 6'd0);
    send_word(FuncMarker, 64'd0, 6'd1);
    send_word(FuncMarker, 64'd0, 6'd1);
    send_word(FuncMarker, '1, 6'd63);
    send_word(FuncQuery, 64'h8000_0000_0000_0002, 6'd0);
    send_word(FuncOverlap, 64'h8000_0000_0000_0003, 6'd63);
    for (int i = 0; i < 36; i++)
      send_word(FuncInsert, (64'd1 << (i % 62 + 2)) | 64'h4000_0000_0000_0000, 6'd0);
    send_word(FuncInsert, 64'hAAAA_5555_AAAA_5555, 6'd0);
    send_word(FuncInsert, '1, 6'd0);
    send_word(FuncQuery, '1, 6'd0);
    send_word(FuncOverlap, 64'h5555_5555_5555_5555, 6'd0);

    random_phase(260);
    send_idle = 77;
    recv_idle = 37;
    random_phase(270);
    send_idle = 0;
    recv_idle = 0;
    random_phase(270);
    valid_i <= 1'b0;

    guard = 0;
    while (board.owed_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (100) @(posedge clk_i);
    $display("Sent %0d words (%0d keep-marker), checked %0d results.",
             words_sent, marker_words, board.checked);
    $display("Sender and receiver idled in both proportions, then not at all.");
    if (board.errors == 0 && board.owed_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // A marker pass is the slowest kind of word, as it checks rows pairwise;
  // this bound is far above the slowest run with full stalls.
  initial begin
    #40ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== maximal_bitset_antichain_table.f =====
rtl/core/mbat_pkg.sv
rtl/core/mbat_ram.sv
rtl/core/mbat_ctrl.sv
rtl/core/mbat_dp.sv
rtl/core/maximal_bitset_antichain_table.sv
tb/maximal_bitset_antichain_table_test.sv
